FILE: hdl/dimk_pkg.sv
// Package: shared constants, operation codes and memory request type for the key map.
`timescale 1ns / 1ps

package dimk_pkg;

    localparam int DEPTH   = 1024;
    localparam int KEY_W   = 10;
    localparam int DATA_W  = 32;
    localparam int SIZE_W  = 11;
    localparam int CNT_W   = 11;
    localparam int FUNC_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // One cycle's request to the entry memory.
    typedef struct packed {
        logic              we;
        logic [KEY_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [KEY_W-1:0]  raddr;
    } ram_req_t;

endpackage

FILE: hdl/dimk_if.sv
// Interfaces: request, response and configuration channels of the key map.
`timescale 1ns / 1ps

interface dimk_in_if
    import dimk_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] item_value;

    modport source (output valid, output func, output key, output item_value, input ready);
    modport sink   (input valid, input func, input key, input item_value, output ready);
endinterface

interface dimk_out_if
    import dimk_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              status;
    logic [DATA_W-1:0] item_out;
    logic [CNT_W-1:0]  item_count;
    logic [KEY_W-1:0]  highest_key;

    modport source (output valid, output status, output item_out, output item_count,
                    output highest_key, input ready);
    modport sink   (input valid, input status, input item_out, input item_count,
                    input highest_key, output ready);
endinterface

interface dimk_cfg_if
    import dimk_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] table_size;

    modport source (output valid, output table_size, input ready);
    modport sink   (input valid, input table_size, output ready);
endinterface

FILE: hdl/direct_indexed_map_with_max_key.sv
// Top level: direct-indexed key map with occupancy count and highest occupied key.
`timescale 1ns / 1ps

// Direct-indexed map of 1024 words, one per key; a nonzero word marks the key
// occupied. Each request item (add, remove, lookup, clear) gives one response
// item carrying status, the stored word (for in-range lookup and remove; zero
// otherwise), the occupied count and the highest occupied key. All entries live
// in one 1024 x 32 memory with registered read data; add, remove and lookup read
// the entry, and add and remove then write it back when it changes. Removing the
// highest key walks the memory downward one key per cycle until the next occupied
// key is found. Clear, and the pass that follows reset, write zero to every entry
// one per cycle; no request is accepted meanwhile. Keys at or above table_size
// get status 1, except on clear. A response waiting in the output register does
// not block the next request. The user must write table_size on the cfg channel
// only while the block is idle; the block itself does not enforce this.
module direct_indexed_map_with_max_key
    import dimk_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    dimk_in_if.sink    req,
    dimk_out_if.source rsp,
    dimk_cfg_if.sink   cfg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_CLEAR,
        ST_RESULT
    } state_t;

    state_t            state_reg, state_next;
    func_t             func_reg, func_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [KEY_W-1:0]  top_reg, top_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [KEY_W-1:0]  scan_reg, scan_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [KEY_W-1:0]  chk_key_reg, chk_key_next;
    logic [KEY_W-1:0]  clr_addr_reg, clr_addr_next;
    logic              clr_op_reg, clr_op_next;
    logic              res_status_reg, res_status_next;
    logic [DATA_W-1:0] res_word_reg, res_word_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_status_reg, out_status_next;
    logic [DATA_W-1:0] out_word_reg, out_word_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic [KEY_W-1:0]  out_top_reg, out_top_next;

    ram_req_t          ram_req;
    logic [DATA_W-1:0] ram_rdata;
    logic              out_free;
    logic              done;
    logic              vacate;
    logic [CNT_W-1:0]  cnt_dec;

    dimk_ram u_ram (
        .clk     (clk),
        .ram_req (ram_req),
        .rdata   (ram_rdata)
    );

    assign req.ready       = (state_reg == ST_IDLE);
    assign cfg.ready       = 1'b1;
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.item_out    = out_word_reg;
    assign rsp.item_count  = out_cnt_reg;
    assign rsp.highest_key = out_top_reg;

    // Output register can take a new response this cycle.
    assign out_free = !out_valid_reg || rsp.ready;
    assign cnt_dec  = cnt_reg - CNT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        cnt_next        = cnt_reg;
        top_next        = top_reg;
        size_next       = size_reg;
        scan_next       = scan_reg;
        chk_valid_next  = chk_valid_reg;
        chk_key_next    = chk_key_reg;
        clr_addr_next   = clr_addr_reg;
        clr_op_next     = clr_op_reg;
        res_status_next = res_status_reg;
        res_word_next   = res_word_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_word_next   = out_word_reg;
        out_cnt_next    = out_cnt_reg;
        out_top_next    = out_top_reg;
        ram_req         = '0;
        done            = 1'b0;
        vacate          = 1'b0;

        if (cfg.valid)
        begin
            size_next = cfg.table_size;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    func_next       = func_t'(req.func);
                    key_next        = req.key;
                    val_next        = req.item_value;
                    res_status_next = STATUS_OK;
                    res_word_next   = '0;
                    if (func_t'(req.func) == FUNC_CLEAR)
                    begin
                        cnt_next      = '0;
                        top_next      = '0;
                        clr_addr_next = '0;
                        clr_op_next   = 1'b1;
                        state_next    = ST_CLEAR;
                    end
                    else if ({1'b0, req.key} >= size_reg)
                    begin
                        res_status_next = STATUS_RANGE;
                        done            = 1'b1;
                    end
                    else
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = req.key;
                        state_next    = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                case (func_reg)
                    FUNC_LOOKUP:
                    begin
                        res_word_next = ram_rdata;
                        done          = 1'b1;
                    end
                    FUNC_ADD:
                    begin
                        if (val_reg != '0)
                        begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = key_reg;
                            ram_req.wdata = val_reg;
                            if (ram_rdata == '0)
                            begin
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                            if (key_reg > top_reg)
                            begin
                                top_next = key_reg;
                            end
                            done = 1'b1;
                        end
                        else
                        begin
                            vacate = 1'b1;
                        end
                    end
                    FUNC_REMOVE:
                    begin
                        res_word_next = ram_rdata;
                        vacate        = 1'b1;
                    end
                    default:
                    begin
                        done = 1'b1;
                    end
                endcase

                // Zero written over an occupied entry, or a remove.
                if (vacate)
                begin
                    if (ram_rdata == '0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = key_reg;
                        ram_req.wdata = '0;
                        cnt_next      = cnt_dec;
                        if (cnt_dec == '0)
                        begin
                            top_next = '0;
                            done     = 1'b1;
                        end
                        else if (key_reg == top_reg)
                        begin
                            scan_next      = key_reg - KEY_W'(1);
                            chk_valid_next = 1'b0;
                            state_next     = ST_SCAN;
                        end
                        else
                        begin
                            done = 1'b1;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // Read one key per cycle; check the key read the cycle before.
                ram_req.re    = 1'b1;
                ram_req.raddr = scan_reg;
                if (chk_valid_reg && (ram_rdata != '0))
                begin
                    top_next = chk_key_reg;
                    done     = 1'b1;
                end
                else if (chk_valid_reg && (chk_key_reg == '0))
                begin
                    top_next = '0;
                    done     = 1'b1;
                end
                else
                begin
                    chk_valid_next = 1'b1;
                    chk_key_next   = scan_reg;
                    scan_next      = scan_reg - KEY_W'(1);
                end
            end

            ST_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_addr_reg;
                ram_req.wdata = '0;
                clr_addr_next = clr_addr_reg + KEY_W'(1);
                if (clr_addr_reg == '1)
                begin
                    if (clr_op_reg)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_word_next   = res_word_reg;
                    out_cnt_next    = cnt_reg;
                    out_top_next    = top_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Finished item: straight into the output register when it is free.
        if (done)
        begin
            clr_op_next = 1'b0;
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_status_next = res_status_next;
                out_word_next   = res_word_next;
                out_cnt_next    = cnt_next;
                out_top_next    = top_next;
                state_next      = ST_IDLE;
            end
            else
            begin
                state_next = ST_RESULT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            func_reg       <= FUNC_ADD;
            key_reg        <= '0;
            val_reg        <= '0;
            cnt_reg        <= '0;
            top_reg        <= '0;
            size_reg       <= SIZE_W'(DEPTH);
            scan_reg       <= '0;
            chk_valid_reg  <= 1'b0;
            chk_key_reg    <= '0;
            clr_addr_reg   <= '0;
            clr_op_reg     <= 1'b0;
            res_status_reg <= STATUS_OK;
            res_word_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_OK;
            out_word_reg   <= '0;
            out_cnt_reg    <= '0;
            out_top_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            func_reg       <= func_next;
            key_reg        <= key_next;
            val_reg        <= val_next;
            cnt_reg        <= cnt_next;
            top_reg        <= top_next;
            size_reg       <= size_next;
            scan_reg       <= scan_next;
            chk_valid_reg  <= chk_valid_next;
            chk_key_reg    <= chk_key_next;
            clr_addr_reg   <= clr_addr_next;
            clr_op_reg     <= clr_op_next;
            res_status_reg <= res_status_next;
            res_word_reg   <= res_word_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_word_reg   <= out_word_next;
            out_cnt_reg    <= out_cnt_next;
            out_top_reg    <= out_top_next;
        end
    end

endmodule

FILE: hdl/dimk_ram.sv
// Entry memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module dimk_ram
    import dimk_pkg::*;
(
    input  logic              clk,
    input  ram_req_t          ram_req,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ram_req.we)
        begin
            mem[ram_req.waddr] <= ram_req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_req.re)
        begin
            rdata_reg <= mem[ram_req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/dimk_checker.sv
// Checker: port-level properties of the key map, bound to the top level.
`timescale 1ns / 1ps

module dimk_checker
    import dimk_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic              out_status,
    input logic [DATA_W-1:0] out_word,
    input logic [CNT_W-1:0]  out_cnt,
    input logic [KEY_W-1:0]  out_top
);

    // A stalled response stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("response dropped while stalled");

    // Empty map reports highest key zero.
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_cnt == '0) |-> (out_top == '0))
        else $error("highest key nonzero on empty map");

    // Count never exceeds the number of keys.
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_cnt <= CNT_W'(DEPTH)))
        else $error("occupied count above depth");

    // Out-of-range responses carry no word.
    a_range_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == STATUS_RANGE) |-> (out_word == '0))
        else $error("word returned with out-of-range status");

endmodule

bind direct_indexed_map_with_max_key dimk_checker u_dimk_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_status (rsp.status),
    .out_word   (rsp.item_out),
    .out_cnt    (rsp.item_count),
    .out_top    (rsp.highest_key)
);

FILE: dv/direct_indexed_map_with_max_key_tb.sv
// Testbench: directed and random checks of the direct-indexed key map against its own predictor.
`timescale 1ns / 1ps

// The bench drives request items through the req channel and checks every
// response item against a predictor. The predictor keeps its own copy of
// the table, the occupied count, the highest occupied key and table_size.
// - Drivers change inputs at the falling edge. One monitor samples all three
//   handshakes at the rising edge. An accepted request updates the predictor
//   and queues the expected response. An accepted response is checked
//   against the oldest queued one.
// - table_size is written only once the block is idle: the sender is
//   parked and every expected response has arrived.
// - The directed part covers:
//   - empty lookup and remove
//   - extreme keys and words, and overwrite
//   - a zero add over an empty entry and over an occupied entry
//   - the downward scan for the highest key
//   - a lowered size that leaves stored entries out of reach
//   - zero size, and a size above the depth
//   - clear
// - The random phases use several sizes and a hot window of keys, so that
//   removes hit the highest key often.
// - Random gaps on both sides. Some stretches run with no gaps. A long
//   receiver hold-off fills the block until it stalls its input.
// - A watchdog ends the run if nothing is accepted for too long.
module direct_indexed_map_with_max_key_tb;
    import dimk_pkg::*;

    // Worst quiet stretch: a clear or the pass after reset, a full downward
    // scan, a receiver hold-off and a long gap. Taken with margin.
    localparam int STALL_LIMIT = 12000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 8;     // pause before a register write and at the end

    typedef struct packed {
        logic              status;
        logic [DATA_W-1:0] word;
        logic [CNT_W-1:0]  count;
        logic [KEY_W-1:0]  top;
    } map_reply_t;

    // Predictor of the table plus the store of replies still owed by the block.
    class key_map_scoreboard;
        logic [DATA_W-1:0] store [DEPTH];
        logic [CNT_W-1:0]  count;
        logic [KEY_W-1:0]  top;
        logic [SIZE_W-1:0] size;
        map_reply_t        expected_replies [$];
        int                failures;

        function new();
            foreach (store[i]) store[i] = '0;
            count    = '0;
            top      = '0;
            size     = SIZE_W'(DEPTH);
            failures = 0;
        endfunction

        function void set_size(logic [SIZE_W-1:0] s);
            size = s;
        endfunction

        function bit idle();
            return expected_replies.size() == 0;
        endfunction

        // Next occupied key below k; entries above the size still count here.
        function logic [KEY_W-1:0] next_below(logic [KEY_W-1:0] k);
            int j;
            for (j = int'(k) - 1; j >= 0; j--)
                if (store[j] != '0) return KEY_W'(j);
            return '0;
        endfunction

        function void vacate(logic [KEY_W-1:0] k);
            store[k] = '0;
            if (count != 0) count--;
            if (count == 0) top = '0;
            else if (k == top) top = next_below(k);
        endfunction

        function void note_request(func_t f, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
            map_reply_t  e;
            int unsigned lim;
            lim      = (size < DEPTH) ? size : DEPTH;
            e.status = STATUS_OK;
            e.word   = '0;
            if (f == FUNC_CLEAR) begin
                foreach (store[i]) store[i] = '0;
                count = '0;
                top   = '0;
            end else if (k >= lim) begin
                e.status = STATUS_RANGE;
            end else if (f == FUNC_ADD) begin
                if (v != '0) begin
                    if (store[k] == '0) count++;
                    store[k] = v;
                    if (k > top) top = k;
                end else if (store[k] != '0) begin
                    vacate(k);     // zero over an occupied entry is a removal
                end
            end else if (f == FUNC_REMOVE) begin
                e.word = store[k];
                if (e.word != '0) vacate(k);
            end else begin
                e.word = store[k];
            end
            e.count = count;
            e.top   = top;
            expected_replies.push_back(e);
        endfunction

        function void check_reply(map_reply_t got);
            map_reply_t e;
            if (expected_replies.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: reply with none expected: st=%0b word=%h cnt=%0d top=%0d",
                             $time, got.status, got.word, got.count, got.top);
                return;
            end
            e = expected_replies.pop_front();
            if (got !== e) begin
                failures++;
                if (failures <= 10) begin
                    $display("%0t: reply mismatch", $time);
                    $display("    expected st=%0b word=%h cnt=%0d top=%0d",
                             e.status, e.word, e.count, e.top);
                    $display("    actual   st=%0b word=%h cnt=%0d top=%0d",
                             got.status, got.word, got.count, got.top);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dimk_in_if  req ();
    dimk_out_if rsp ();
    dimk_cfg_if cfg ();

    direct_indexed_map_with_max_key u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    key_map_scoreboard sb = new();

    int quiet_cycles = 0;
    bit no_gaps      = 0;   // stretch with no idling on either side
    bit hold_replies = 0;   // asks the receiver for one long hold-off

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one item after a random gap; returns right after the accepting edge.
    task automatic issue(func_t f, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            req.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req.valid      = 1'b1;
        req.func       = f;
        req.key        = k;
        req.item_value = v;
        do @(posedge clk); while (!req.ready);
    endtask

    // Park the sender and wait until every reply owed has come back.
    task automatic drain();
        @(negedge clk);
        req.valid = 1'b0;
        while (!sb.idle()) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] s);
        drain();
        @(negedge clk);
        cfg.valid      = 1'b1;
        cfg.table_size = s;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // Random items at the current size. Half the in-range keys come from a
    // 32-key window, and some removes aim at the current highest key, so
    // the downward scan is hit often.
    task automatic run_random(int n, bit with_hold);
        int unsigned       lim;
        int unsigned       hot_base;
        int                i;
        int                r;
        func_t             f;
        logic [KEY_W-1:0]  k;
        logic [DATA_W-1:0] v;
        lim      = (sb.size < DEPTH) ? sb.size : DEPTH;
        hot_base = (lim > 32) ? $urandom_range(0, lim - 32) : 0;
        for (i = 0; i < n; i++) begin
            if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            if (with_hold && i == n / 2) hold_replies = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 2)       f = FUNC_CLEAR;
            else if (r < 45) f = FUNC_ADD;
            else if (r < 70) f = FUNC_REMOVE;
            else             f = FUNC_LOOKUP;
            r = $urandom_range(0, 99);
            if (lim == 0 || (lim < DEPTH && r < 10))
                k = KEY_W'($urandom_range(lim, DEPTH - 1));
            else if (f == FUNC_REMOVE && r < 35 && sb.top < lim)
                k = sb.top;
            else if (lim > 32 && r < 60)
                k = KEY_W'(hot_base + $urandom_range(0, 31));
            else
                k = KEY_W'($urandom_range(0, lim - 1));
            r = $urandom_range(0, 99);
            if (r < 15)      v = '0;
            else if (r < 20) v = '1;
            else if (r < 25) v = $urandom_range(1, 15);
            else             v = $urandom;
            issue(f, k, v);
        end
        no_gaps = 1'b0;
    endtask

    // All three handshakes are sampled here, at the rising edge.
    initial
    begin : handshake_monitor
        bit         fired;
        map_reply_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n) begin
                fired = 1'b0;
                if (req.valid && req.ready) begin
                    sb.note_request(func_t'(req.func), req.key, req.item_value);
                    fired = 1'b1;
                end
                if (rsp.valid && rsp.ready) begin
                    got.status = rsp.status;
                    got.word   = rsp.item_out;
                    got.count  = rsp.item_count;
                    got.top    = rsp.highest_key;
                    sb.check_reply(got);
                    fired = 1'b1;
                end
                if (cfg.valid && cfg.ready) begin
                    sb.set_size(cfg.table_size);
                    fired = 1'b1;
                end
                quiet_cycles = fired ? 0 : quiet_cycles + 1;
            end
        end
    end

    // Receiver: random ready, runs with no gaps, and one long hold-off on request.
    initial
    begin : reply_sink
        int len;
        int r;
        bit rdy;
        rsp.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_replies) begin
                hold_replies = 1'b0;
                rsp.ready    = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                r = $urandom_range(0, 99);
                if (no_gaps) begin
                    rdy = 1'b1;
                    len = 1;
                end else if (r < 65) begin
                    rdy = 1'b1;
                    len = $urandom_range(1, 8);
                end else begin
                    rdy = 1'b0;
                    len = (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
                end
                rsp.ready = rdy;
                repeat (len - 1) @(negedge clk);
            end
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < STALL_LIMIT) @(posedge clk);
        $display("direct_indexed_map_with_max_key_tb NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.func       = FUNC_LOOKUP;
        req.key        = '0;
        req.item_value = '0;
        cfg.valid      = 1'b0;
        cfg.table_size = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Full size first.
        write_size(SIZE_W'(DEPTH));
        issue(FUNC_LOOKUP, 10'd0, '0);              // empty table
        issue(FUNC_REMOVE, 10'd5, '0);              // remove of an empty entry
        issue(FUNC_ADD, 10'd0, 32'h0000_0001);
        issue(FUNC_ADD, 10'd1023, 32'hFFFF_FFFF);
        issue(FUNC_ADD, 10'd512, 32'h5A5A_A5A5);
        issue(FUNC_ADD, 10'd512, 32'hA5A5_5A5A);    // overwrite, count holds
        issue(FUNC_LOOKUP, 10'd1023, '0);
        issue(FUNC_ADD, 10'd7, '0);                 // zero over empty: no change
        issue(FUNC_REMOVE, 10'd1023, '0);           // scan down to 512
        issue(FUNC_ADD, 10'd512, '0);               // zero over occupied: removal and scan
        issue(FUNC_REMOVE, 10'd0, '0);              // table goes empty
        issue(FUNC_ADD, 10'd900, 32'h0000_0003);
        issue(FUNC_ADD, 10'd200, 32'h0000_0004);

        // Lowered size: 900 and 200 stay stored and counted but out of reach.
        write_size(11'd8);
        issue(FUNC_LOOKUP, 10'd900, '0);
        issue(FUNC_ADD, 10'd3, 32'h0000_0009);
        issue(FUNC_REMOVE, 10'd3, '0);              // highest key stays 900
        issue(FUNC_ADD, 10'd8, 32'h0000_0001);      // first key past the size

        // Zero size: all keys out of range, clear still works.
        write_size(11'd0);
        issue(FUNC_ADD, 10'd0, 32'h0000_0001);
        issue(FUNC_CLEAR, 10'd0, '0);

        // Size above the depth: the depth is in effect.
        write_size(11'd2047);
        issue(FUNC_ADD, 10'd1023, 32'h0000_0002);
        issue(FUNC_LOOKUP, 10'd200, '0);
        issue(FUNC_ADD, 10'd1, 32'h8000_0000);
        issue(FUNC_REMOVE, 10'd1023, '0);
        issue(FUNC_CLEAR, 10'd1023, '0);

        // Random phases over several sizes, extremes included.
        write_size(SIZE_W'(DEPTH));
        run_random(200, 1'b1);
        write_size(11'd1);
        run_random(60, 1'b0);
        write_size(11'd40);
        run_random(150, 1'b0);
        write_size(11'd2047);
        run_random(200, 1'b1);
        write_size(11'd0);
        run_random(20, 1'b0);
        write_size(SIZE_W'($urandom_range(2, DEPTH - 1)));
        run_random(150, 1'b0);
        write_size(SIZE_W'(DEPTH));
        run_random(200, 1'b0);

        drain();
        if (sb.failures == 0)
            $display("direct_indexed_map_with_max_key_tb OK");
        else
            $display("direct_indexed_map_with_max_key_tb NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
hdl/dimk_pkg.sv
hdl/dimk_if.sv
hdl/dimk_ram.sv
hdl/direct_indexed_map_with_max_key.sv
hdl/dimk_checker.sv
dv/direct_indexed_map_with_max_key_tb.sv
